>>> rtl/brff_pkg.sv
// Package for the bitmap range find-first block.
// Holds the row geometry, field widths, request codes, sequencer states and scan control.
// Depends on nothing.
`timescale 1ns / 1ps

package brff_pkg;

	localparam int BYTE_W    = 8;
	localparam int ROW_BYTES = 8;
	localparam int ROW_BITS  = BYTE_W * ROW_BYTES;
	localparam int OFF_W     = $clog2(ROW_BITS);
	localparam int LANE_W    = $clog2(ROW_BYTES);
	localparam int IDX_W     = 9;
	localparam int BIT_W     = 13;
	localparam int POS_W     = 12;
	localparam int ROW_W     = BIT_W - OFF_W;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_FIND  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_FIND,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             polarity;
		logic             first;
		logic             last;
		logic [OFF_W-1:0] lo;
		logic [OFF_W-1:0] hi;
	} scan_ctrl_t;

endpackage

>>> rtl/brff_req_if.sv
// Request channel of the bitmap range find-first block.
// Carries valid, ready and the request word; depends on brff_pkg.
`timescale 1ns / 1ps

interface brff_req_if;

	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [brff_pkg::IDX_W-1:0]  byte_index;
	logic [brff_pkg::BYTE_W-1:0] byte_value;
	logic [brff_pkg::BIT_W-1:0]  start_bit;
	logic [brff_pkg::BIT_W-1:0]  end_bit;
	logic                       polarity;

	modport source (
		output valid, req_type, byte_index, byte_value, start_bit, end_bit, polarity,
		input  ready
	);

	modport sink (
		input  valid, req_type, byte_index, byte_value, start_bit, end_bit, polarity,
		output ready
	);

endinterface

>>> rtl/brff_rsp_if.sv
// Response channel of the bitmap range find-first block.
// Carries valid, ready and the result word; depends on brff_pkg.
`timescale 1ns / 1ps

interface brff_rsp_if;

	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [brff_pkg::POS_W-1:0] position;

	modport source (
		output valid, found, position,
		input  ready
	);

	modport sink (
		input  valid, found, position,
		output ready
	);

endinterface

>>> rtl/brff_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module brff_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/brff_scan.sv
// Row match unit: masks one 64-bit map row to the search range and finds its lowest match.
// Depends on brff_pkg.
`timescale 1ns / 1ps

module brff_scan (
	input  logic [brff_pkg::ROW_BITS-1:0] row_data,
	input  brff_pkg::scan_ctrl_t          ctrl,
	output logic                          hit,
	output logic [brff_pkg::OFF_W-1:0]    offset
);

	logic [brff_pkg::ROW_BITS-1:0] cand;
	logic [brff_pkg::ROW_BITS-1:0] lo_mask;
	logic [brff_pkg::ROW_BITS-1:0] hi_mask;
	logic [brff_pkg::ROW_BITS-1:0] masked;
	logic [brff_pkg::ROW_BITS-1:0] lowest;

	assign cand    = ctrl.polarity ? row_data : ~row_data;
	assign lo_mask = ctrl.first ? ({brff_pkg::ROW_BITS{1'b1}} << ctrl.lo)
	                            : {brff_pkg::ROW_BITS{1'b1}};
	assign hi_mask = ctrl.last ? ({brff_pkg::ROW_BITS{1'b1}} >> (~ctrl.hi))
	                           : {brff_pkg::ROW_BITS{1'b1}};
	assign masked  = cand & lo_mask & hi_mask;
	assign lowest  = masked & (~masked + brff_pkg::ROW_BITS'(1));
	assign hit     = |masked;

	// The lowest match is one-hot, so each offset bit is the OR of the positions that carry it.
	always_comb begin
		offset = '0;
		for (int b = 0; b < brff_pkg::OFF_W; b++) begin
			for (int j = 0; j < brff_pkg::ROW_BITS; j++) begin
				offset[b] = offset[b] | (lowest[j] & j[b]);
			end
		end
	end

endmodule

>>> rtl/bitmap_range_find_first.sv
// Bitmap with byte writes and a range search for the first set or clear bit.
// A find word reads one 64-bit row per cycle and stops at the first row with a match or at the
// last row; a write reads and writes back one row, and an empty range goes straight to the result.
// One word is in progress at a time; the next can be taken in the cycle after the result is loaded,
// which waits while the previous result is still held. After reset the map is zeroed one row
// per cycle (64 rows by default). Depends on brff_pkg, the interfaces, brff_ram, brff_scan.
`timescale 1ns / 1ps

module bitmap_range_find_first #(
	parameter int MAP_BITS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	brff_req_if.sink    req,
	brff_rsp_if.source  rsp
);

	localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
	localparam int ROWS      = (MAP_BYTES + brff_pkg::ROW_BYTES - 1) / brff_pkg::ROW_BYTES;
	localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;

	brff_pkg::state_t state_q;
	brff_pkg::state_t state_d;

	logic [AW-1:0]                    clr_q;
	logic [brff_pkg::ROW_W-1:0]       row_q;
	logic [brff_pkg::ROW_W-1:0]       start_row_q;
	logic [brff_pkg::ROW_W-1:0]       last_row_q;
	logic [brff_pkg::ROW_W-1:0]       chk_row_q;
	logic                             chk_vld_q;
	logic [brff_pkg::OFF_W-1:0]       lo_q;
	logic [brff_pkg::OFF_W-1:0]       hi_q;
	logic                             pol_q;
	logic [brff_pkg::IDX_W-1:0]       idx_q;
	logic [brff_pkg::BYTE_W-1:0]      byte_q;
	logic                             wr_ok_q;
	logic                             res_found_q;
	logic [brff_pkg::POS_W-1:0]       res_pos_q;
	logic                             out_vld_q;
	logic                             out_found_q;
	logic [brff_pkg::POS_W-1:0]       out_pos_q;

	logic [brff_pkg::BIT_W-1:0]       end_clamp;
	logic [brff_pkg::BIT_W-1:0]       last_bit;
	logic                             range_empty;
	logic                             accept;
	logic                             issue_ok;
	logic                             out_free;
	logic [AW-1:0]                    wr_addr;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [brff_pkg::ROW_BITS-1:0]    ram_wdata;
	logic                             ram_re;
	logic [AW-1:0]                    ram_raddr;
	logic [brff_pkg::ROW_BITS-1:0]    ram_rdata;
	logic [brff_pkg::ROW_BITS-1:0]    merged;

	brff_pkg::scan_ctrl_t             scan_ctrl;
	logic                             scan_hit;
	logic [brff_pkg::OFF_W-1:0]       scan_off;

	assign req.ready   = (state_q == brff_pkg::ST_IDLE);
	assign accept      = req.valid && req.ready;
	assign end_clamp   = (32'(req.end_bit) > MAP_BITS) ? brff_pkg::BIT_W'(MAP_BITS) : req.end_bit;
	assign last_bit    = end_clamp - brff_pkg::BIT_W'(1);
	assign range_empty = (req.start_bit >= end_clamp);
	assign issue_ok    = (row_q <= last_row_q);
	assign out_free    = !out_vld_q || rsp.ready;
	assign wr_addr     = AW'(idx_q[brff_pkg::IDX_W-1:brff_pkg::LANE_W]);

	assign rsp.valid    = out_vld_q;
	assign rsp.found    = out_found_q;
	assign rsp.position = out_pos_q;

	assign scan_ctrl.polarity = pol_q;
	assign scan_ctrl.first    = (chk_row_q == start_row_q);
	assign scan_ctrl.last     = (chk_row_q == last_row_q);
	assign scan_ctrl.lo       = lo_q;
	assign scan_ctrl.hi       = hi_q;

	brff_ram #(
		.WIDTH (brff_pkg::ROW_BITS),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	brff_scan u_scan (
		.row_data (ram_rdata),
		.ctrl     (scan_ctrl),
		.hit      (scan_hit),
		.offset   (scan_off)
	);

	always_comb begin
		for (int i = 0; i < brff_pkg::ROW_BYTES; i++) begin
			if (idx_q[brff_pkg::LANE_W-1:0] == brff_pkg::LANE_W'(i)) begin
				merged[i*brff_pkg::BYTE_W +: brff_pkg::BYTE_W] = byte_q;
			end else begin
				merged[i*brff_pkg::BYTE_W +: brff_pkg::BYTE_W] =
					ram_rdata[i*brff_pkg::BYTE_W +: brff_pkg::BYTE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brff_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = AW'(row_q);
		case (state_q)
			brff_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == AW'(ROWS - 1)) begin
					state_d = brff_pkg::ST_IDLE;
				end
			end
			brff_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == brff_pkg::REQ_WRITE) begin
						state_d = brff_pkg::ST_WR_RD;
					end else if (range_empty) begin
						state_d = brff_pkg::ST_RESP;
					end else begin
						state_d = brff_pkg::ST_FIND;
					end
				end
			end
			brff_pkg::ST_WR_RD: begin
				ram_re    = wr_ok_q;
				ram_raddr = wr_addr;
				state_d   = brff_pkg::ST_WR_WB;
			end
			brff_pkg::ST_WR_WB: begin
				ram_we    = wr_ok_q;
				ram_waddr = wr_addr;
				ram_wdata = merged;
				state_d   = brff_pkg::ST_RESP;
			end
			brff_pkg::ST_FIND: begin
				ram_re = issue_ok;
				if (chk_vld_q && (scan_hit || scan_ctrl.last)) begin
					state_d = brff_pkg::ST_RESP;
				end
			end
			brff_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = brff_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brff_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			chk_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == brff_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				chk_vld_q <= 1'b0;
			end else if (state_q == brff_pkg::ST_FIND) begin
				chk_vld_q <= issue_ok;
			end
			if ((state_q == brff_pkg::ST_RESP) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q       <= req.start_bit[brff_pkg::BIT_W-1:brff_pkg::OFF_W];
			start_row_q <= req.start_bit[brff_pkg::BIT_W-1:brff_pkg::OFF_W];
			last_row_q  <= last_bit[brff_pkg::BIT_W-1:brff_pkg::OFF_W];
			lo_q        <= req.start_bit[brff_pkg::OFF_W-1:0];
			hi_q        <= last_bit[brff_pkg::OFF_W-1:0];
			pol_q       <= req.polarity;
			idx_q       <= req.byte_index;
			byte_q      <= req.byte_value;
			wr_ok_q     <= (32'(req.byte_index) < MAP_BYTES);
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end else if (state_q == brff_pkg::ST_FIND) begin
			row_q     <= row_q + brff_pkg::ROW_W'(1);
			chk_row_q <= row_q;
			if (chk_vld_q && scan_hit) begin
				res_found_q <= 1'b1;
				res_pos_q   <= brff_pkg::POS_W'({chk_row_q, scan_off});
			end
		end
		if ((state_q == brff_pkg::ST_RESP) && out_free) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

`ifndef SYNTHESIS
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == brff_pkg::ST_RESP))
		else $error("Result word loaded outside the response state.");

	a_chk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brff_pkg::ST_FIND && chk_vld_q) |->
			(chk_row_q >= start_row_q && chk_row_q <= last_row_q))
		else $error("Row checked outside the search range.");

	a_hit_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> ((MAP_BITS > 4096) || (32'(rsp.position) < MAP_BITS)))
		else $error("Reported position lies beyond the map.");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brff_pkg::ST_CLEAR) |=> !(accept && $past(clr_q != AW'(ROWS - 1))))
		else $error("Request word taken before the map was cleared.");
`endif

endmodule

>>> verif/tb.sv
// Testbench for bitmap_range_find_first: directed table of writes and finds, then random traffic.
// Each result word is checked against its table entry or, for untyped and random words, against
// a local model of the bitmap. Depends on brff_pkg, brff_req_if, brff_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb;

	localparam int MAP_BITS     = 4096;
	localparam int MAP_BYTES    = MAP_BITS / 8;
	localparam int RANDOM_WORDS = 1300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic                        req_type;
		logic [brff_pkg::IDX_W-1:0]  byte_index;
		logic [brff_pkg::BYTE_W-1:0] byte_value;
		logic [brff_pkg::BIT_W-1:0]  start_bit;
		logic [brff_pkg::BIT_W-1:0]  end_bit;
		logic                        polarity;
	} req_word_t;

	typedef struct packed {
		logic                       found;
		logic [brff_pkg::POS_W-1:0] position;
	} rsp_word_t;

	typedef struct {
		req_word_t word;
		bit        typed;
		rsp_word_t rsp;
	} plan_row_t;

	logic clk;
	logic arst_n;

	brff_req_if req_if ();
	brff_rsp_if rsp_if ();

	bitmap_range_find_first #(
		.MAP_BITS(MAP_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	logic [brff_pkg::BYTE_W-1:0] map_mirror [MAP_BYTES];
	rsp_word_t         pending_rsp [$];
	plan_row_t         plan [$];
	bit                steady;
	int                errors;
	int                n_writes;
	int                n_finds;
	int                n_hits;
	int                quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_word_t find_first(input req_word_t w);
		rsp_word_t r;
		int        k;
		int        stop;
		r = '0;
		if (w.req_type == brff_pkg::REQ_WRITE) begin
			if (w.byte_index < MAP_BYTES)
				map_mirror[w.byte_index] = w.byte_value;
			return r;
		end
		stop = (w.end_bit > MAP_BITS) ? MAP_BITS : int'(w.end_bit);
		if (w.start_bit >= w.end_bit)
			return r;
		for (k = int'(w.start_bit); k < stop; k++) begin
			if (map_mirror[k / 8][k % 8] == w.polarity) begin
				r.found    = 1'b1;
				r.position = brff_pkg::POS_W'(k);
				return r;
			end
		end
		return r;
	endfunction

	function automatic plan_row_t find_row(input int s, input int e, input bit pol,
	                                       input bit typed, input bit f, input int p);
		plan_row_t row;
		row.word           = '0;
		row.word.req_type  = brff_pkg::REQ_FIND;
		row.word.start_bit = brff_pkg::BIT_W'(s);
		row.word.end_bit   = brff_pkg::BIT_W'(e);
		row.word.polarity  = pol;
		row.typed          = typed;
		row.rsp.found      = f;
		row.rsp.position   = brff_pkg::POS_W'(p);
		return row;
	endfunction

	function automatic plan_row_t write_row(input int idx,
	                                        input logic [brff_pkg::BYTE_W-1:0] val);
		plan_row_t row;
		row.word            = '0;
		row.word.req_type   = brff_pkg::REQ_WRITE;
		row.word.byte_index = brff_pkg::IDX_W'(idx);
		row.word.byte_value = val;
		row.typed           = 1'b1;
		row.rsp             = '0;
		return row;
	endfunction

	task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
		rsp_word_t guess;
		while (!steady && $urandom_range(99) < 27) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.req_type   <= w.req_type;
		req_if.byte_index <= w.byte_index;
		req_if.byte_value <= w.byte_value;
		req_if.start_bit  <= w.start_bit;
		req_if.end_bit    <= w.end_bit;
		req_if.polarity   <= w.polarity;
		do
			@(posedge clk);
		while (!(req_if.valid && req_if.ready));
		guess = find_first(w);
		pending_rsp.push_back(typed ? typed_rsp : guess);
		if (w.req_type == brff_pkg::REQ_WRITE)
			n_writes++;
		else
			n_finds++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_if.ready <= steady || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, got found=%0d position=%0d",
				         $time, rsp_if.found, rsp_if.position);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_if.found !== want.found) begin
					errors++;
					$display("%0t: found mismatch, expected %0d, got %0d",
					         $time, want.found, rsp_if.found);
				end
				if (rsp_if.position !== want.position) begin
					errors++;
					$display("%0t: position mismatch, expected %0d, got %0d",
					         $time, want.position, rsp_if.position);
				end
				if (rsp_if.found === 1'b1)
					n_hits++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		req_word_t                   w;
		logic [brff_pkg::BYTE_W-1:0] bg;
		int                          s;
		int                          e;
		int                          pick;
		int                          recent;
		clk               = 1'b0;
		arst_n            = 1'b0;
		steady            = 1'b0;
		errors            = 0;
		n_writes          = 0;
		n_finds           = 0;
		n_hits            = 0;
		quiet_cycles      = 0;
		recent            = 0;
		req_if.valid      = 1'b0;
		req_if.req_type   = brff_pkg::REQ_WRITE;
		req_if.byte_index = '0;
		req_if.byte_value = '0;
		req_if.start_bit  = '0;
		req_if.end_bit    = '0;
		req_if.polarity   = 1'b0;
		rsp_if.ready      = 1'b0;
		foreach (map_mirror[j])
			map_mirror[j] = '0;

		plan.push_back(find_row(0, 4096, 1, 1, 0, 0));
		plan.push_back(find_row(0, 4096, 0, 1, 1, 0));
		plan.push_back(find_row(4095, 4096, 0, 1, 1, 4095));
		plan.push_back(find_row(100, 100, 0, 1, 0, 0));
		plan.push_back(find_row(8191, 0, 0, 1, 0, 0));
		plan.push_back(find_row(4096, 8191, 0, 1, 0, 0));
		plan.push_back(find_row(4000, 8191, 0, 1, 1, 4000));
		plan.push_back(write_row(0, 8'hFF));
		plan.push_back(write_row(511, 8'h80));
		plan.push_back(find_row(0, 4096, 1, 1, 1, 0));
		plan.push_back(find_row(0, 4096, 0, 1, 1, 8));
		plan.push_back(find_row(1, 8191, 1, 1, 1, 1));
		plan.push_back(find_row(8, 4096, 1, 1, 1, 4095));
		plan.push_back(find_row(8, 4095, 1, 1, 0, 0));
		plan.push_back(write_row(3, 8'h5A));
		plan.push_back(find_row(26, 29, 1, 0, 0, 0));
		// A set bit sits just past the end within the same byte and must not be reported.
		plan.push_back(find_row(24, 25, 1, 0, 0, 0));
		plan.push_back(find_row(0, 8, 0, 1, 0, 0));
		plan.push_back(write_row(0, 8'h7F));
		plan.push_back(find_row(0, 8, 0, 0, 0, 0));
		plan.push_back(write_row(511, 8'hFF));
		plan.push_back(find_row(4088, 8191, 0, 1, 0, 0));
		plan.push_back(find_row(30, 4095, 1, 0, 0, 0));
		plan.push_back(find_row(64, 128, 0, 0, 0, 0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[r])
			send_word(plan[r].word, plan[r].typed, plan[r].rsp);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady       = (i >= 500 && i < 700);
			bg           = (i < RANDOM_WORDS / 2) ? 8'h00 : 8'hFF;
			w.byte_index = brff_pkg::IDX_W'($urandom_range(511));
			w.byte_value = brff_pkg::BYTE_W'($urandom_range(255));
			w.start_bit  = brff_pkg::BIT_W'($urandom_range(8191));
			w.end_bit    = brff_pkg::BIT_W'($urandom_range(8191));
			w.polarity   = 1'($urandom_range(1));
			w.req_type   = ($urandom_range(99) < 40) ? brff_pkg::REQ_WRITE : brff_pkg::REQ_FIND;
			if (w.req_type == brff_pkg::REQ_WRITE) begin
				case ($urandom_range(2))
					0: w.byte_value = bg;
					1: w.byte_value = bg ^ (8'h01 << $urandom_range(7));
					default: ;
				endcase
				recent = int'(w.byte_index);
			end else begin
				pick = $urandom_range(99);
				if (pick < 30)
					s = recent * 8 + int'($urandom_range(15));
				else if (pick < 88)
					s = int'($urandom_range(4096));
				else
					s = int'($urandom_range(8191));
				pick = $urandom_range(99);
				if (pick < 60)
					e = s + int'($urandom_range(80));
				else if (pick < 85)
					e = int'($urandom_range(4096));
				else
					e = int'($urandom_range(8191));
				if (e > 8191)
					e = 8191;
				w.start_bit = brff_pkg::BIT_W'(s);
				w.end_bit   = brff_pkg::BIT_W'(e);
			end
			send_word(w, 1'b0, '0);
		end
		steady       = 1'b0;
		req_if.valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d byte writes and %0d range finds checked, %0d finds hit a bit",
		         n_writes, n_finds, n_hits);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
